>>> hw/rtl/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types and constants of the double to scaled words converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dts_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_RESOLUTION = 2'd0;
  localparam logic [1:0] REG_WORD_BITS  = 2'd1;
  localparam logic [1:0] REG_WORD_COUNT = 2'd2;

  // reset values
  localparam logic [63:0] RESOLUTION_RST = 64'h3FF0_0000_0000_0000;
  localparam logic [5:0]  WORD_BITS_RST  = 6'd32;
  localparam logic [3:0]  WORD_COUNT_RST = 4'd1;

  localparam int WORD_W = 32;   // widest output word
  localparam int DEN_W  = 54;   // divisor is twice a 53-bit mantissa
  localparam int SW     = 14;   // signed exponent arithmetic

  // per-item control that rides along the pipeline
  typedef struct packed {
    logic       zero;   // result forced to zero
    logic       sat;    // result saturated
    logic [5:0] wb;     // clamped bits per word
    logic [3:0] wc;     // clamped words per item
  } ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/dts_in_if.sv
// ----------------------------------------------------------------------------
// dts_in_if
// Input channel: one binary64 value per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface dts_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;

  modport source (output valid, output value_bits, input ready);
  modport sink   (input valid, input value_bits, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/dts_out_if.sv
// ----------------------------------------------------------------------------
// dts_out_if
// Result channel: one output word per transfer, a run of words per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface dts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  word_index;
  logic [31:0] word_value;
  logic        saturated;
  logic        last;

  modport source (output valid, output word_index, output word_value,
                  output saturated, output last, input ready);
  modport sink   (input valid, input word_index, input word_value,
                  input saturated, input last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/dts_front.sv
// ----------------------------------------------------------------------------
// dts_front
// Unpacks operands, classifies, aligns the dividend and checks saturation.
// Four register stages; the last one hands the division its start values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dts_front #(
  parameter int MAX_WORDS = 8,
  parameter int QW        = 32 * MAX_WORDS,
  parameter int XW        = QW + 108,
  parameter int TW        = $clog2(QW + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [63:0]                value_bits,
  input  wire logic [63:0]                res_bits,
  input  wire logic [5:0]                 wb_cfg,
  input  wire logic [3:0]                 wc_cfg,
  output logic                            v_o,
  output dts_pkg::ctl_t                   ctl_o,
  output logic [dts_pkg::DEN_W-1:0]       rem_o,
  output logic [dts_pkg::DEN_W-1:0]       den_o,
  output logic [QW-1:0]                   lo_o
);

  // ---------------- stage A: unpack and classify
  logic [10:0] exv, exr;
  logic [52:0] mv, mr;
  logic signed [dts_pkg::SW-1:0] ev, er, d, lim;
  logic [5:0]    wb;
  logic [3:0]    wc;
  logic [TW-1:0] t;
  logic r_ok, v_spec, v_nan, v_neg, zero, sat, big;
  dts_pkg::ctl_t ctl_a_nxt;

  always_comb begin
    exv = value_bits[62:52];
    exr = res_bits[62:52];
    mv  = {(exv != 11'd0), value_bits[51:0]};
    mr  = {(exr != 11'd0), res_bits[51:0]};
    // a zero exponent field scales like exponent one
    ev  = $signed({3'b000, (exv == 11'd0) ? 11'd1 : exv}) - 14'sd1075;
    er  = $signed({3'b000, (exr == 11'd0) ? 11'd1 : exr}) - 14'sd1075;
    d   = ev - er;

    if (wb_cfg == 6'd0)       wb = 6'd1;
    else if (wb_cfg > 6'd32)  wb = 6'd32;
    else                      wb = wb_cfg;
    if (wc_cfg == 4'd0)                   wc = 4'd1;
    else if (wc_cfg > 4'(MAX_WORDS))      wc = 4'(MAX_WORDS);
    else                                  wc = wc_cfg;
    t   = TW'(10'(wb) * 10'(wc));
    lim = $signed(14'(t)) + 14'sd53;

    r_ok   = !res_bits[63] && (exr != 11'h7FF) && (res_bits[62:0] != 63'd0);
    v_neg  = value_bits[63];
    v_spec = (exv == 11'h7FF);
    v_nan  = v_spec && (value_bits[51:0] != 52'd0);
    big    = (d >= lim);
    zero   = !r_ok || v_neg || v_nan ||
             (!v_spec && ((mv == 53'd0) || (d <= -14'sd55)));
    sat    = !zero && (v_spec || big);

    ctl_a_nxt.zero = zero;
    ctl_a_nxt.sat  = sat;
    ctl_a_nxt.wb   = wb;
    ctl_a_nxt.wc   = wc;
  end

  logic                          va_r;
  dts_pkg::ctl_t                 ctl_a_r;
  logic [52:0]                   a_r, b_r;
  logic signed [dts_pkg::SW-1:0] s_r;
  logic [TW-1:0]                 t_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_a_r <= ctl_a_nxt;
      a_r     <= mv;
      b_r     <= mr;
      s_r     <= d + 14'sd1;
      t_a_r   <= t;
    end
  end

  // ---------------- stage B: scale value mantissa by 2^s (floor when s < 0)
  logic [dts_pkg::SW-1:0] nsh;
  logic [XW-1:0]          x_nxt;

  always_comb begin
    nsh = dts_pkg::SW'(-s_r);
    if (s_r[dts_pkg::SW-1]) x_nxt = {{(XW-53){1'b0}}, a_r} >> nsh[12:0];
    else                    x_nxt = {{(XW-53){1'b0}}, a_r} << s_r[12:0];
  end

  logic          vb_r;
  dts_pkg::ctl_t ctl_b_r;
  logic [XW-1:0] x_b_r;
  logic [52:0]   b_b_r;
  logic [TW-1:0] t_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_b_r <= ctl_a_r;
      x_b_r   <= x_nxt;
      b_b_r   <= b_r;
      t_b_r   <= t_a_r;
    end
  end

  // ---------------- stage C: add half a step (b over divisor 2b)
  logic          vc_r;
  dts_pkg::ctl_t ctl_c_r;
  logic [XW-1:0] x_c_r;
  logic [52:0]   b_c_r;
  logic [TW-1:0] t_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_c_r <= ctl_b_r;
      x_c_r   <= x_b_r + {{(XW-53){1'b0}}, b_b_r};
      b_c_r   <= b_b_r;
      t_c_r   <= t_b_r;
    end
  end

  // ---------------- stage D: quotient >= 2^T exactly when (x >> T) >= 2b
  logic [XW-1:0]               hi;
  logic [dts_pkg::DEN_W-1:0]   den;
  logic                        satq;
  dts_pkg::ctl_t               ctl_d_nxt;

  always_comb begin
    hi   = x_c_r >> t_c_r;
    den  = {b_c_r, 1'b0};
    satq = (hi[XW-1:dts_pkg::DEN_W] != '0) || (hi[dts_pkg::DEN_W-1:0] >= den);
    ctl_d_nxt     = ctl_c_r;
    ctl_d_nxt.sat = ctl_c_r.sat || (!ctl_c_r.zero && satq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= vc_r;
    end
  end

  // high part is below the divisor whenever the item is neither saturated nor forced to zero
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_o <= ctl_d_nxt;
      den_o <= den;
      rem_o <= x_c_r[QW+dts_pkg::DEN_W-1:QW];
      lo_o  <= x_c_r[QW-1:0];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/dts_div_stage.sv
// ----------------------------------------------------------------------------
// dts_div_stage
// One stage of the restoring divider: two quotient bits per stage.
// The dividend bits leave the top of sh while quotient bits enter the bottom.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dts_div_stage #(
  parameter int QW = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       v_i,
  input  wire dts_pkg::ctl_t              ctl_i,
  input  wire logic [dts_pkg::DEN_W-1:0]  rem_i,
  input  wire logic [dts_pkg::DEN_W-1:0]  den_i,
  input  wire logic [QW-1:0]              sh_i,
  output logic                            v_o,
  output dts_pkg::ctl_t                   ctl_o,
  output logic [dts_pkg::DEN_W-1:0]       rem_o,
  output logic [dts_pkg::DEN_W-1:0]       den_o,
  output logic [QW-1:0]                   sh_o
);

  localparam int STEPS = 2;

  logic [dts_pkg::DEN_W:0]   r2;
  logic [dts_pkg::DEN_W-1:0] rem;
  logic [QW-1:0]             sh;
  logic                      ge;

  // two restoring steps
  always_comb begin
    rem = rem_i;
    sh  = sh_i;
    r2  = '0;
    ge  = 1'b0;
    for (int i = 0; i < STEPS; i++) begin
      r2  = {rem, sh[QW-1]};
      ge  = (r2 >= {1'b0, den_i});
      if (ge) r2 = r2 - {1'b0, den_i};
      rem = r2[dts_pkg::DEN_W-1:0];
      sh  = {sh[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_o <= ctl_i;
      rem_o <= rem;
      den_o <= den_i;
      sh_o  <= sh;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/dts_emit.sv
// ----------------------------------------------------------------------------
// dts_emit
// Output register: holds one quotient and sends it out word by word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dts_emit #(
  parameter int QW = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          v_i,
  input  wire dts_pkg::ctl_t ctl_i,
  input  wire logic [QW-1:0] q_i,
  output logic               en,
  dts_out_if.source          out_ch
);

  logic          busy_r;
  logic [QW-1:0] q_r;
  dts_pkg::ctl_t ctl_r;
  logic [2:0]    idx_r;
  logic [31:0]   mask;
  logic          last, fire, can_load, load;

  always_comb begin
    mask     = 32'((33'd1 << ctl_r.wb) - 33'd1);
    last     = ({1'b0, idx_r} == (ctl_r.wc - 4'd1));
    fire     = busy_r && out_ch.ready;
    can_load = !busy_r || (fire && last);
    load     = v_i && can_load;
    // pipeline moves unless its last stage holds an item with nowhere to go
    en       = can_load || !v_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= 3'd0;
    end else if (fire) begin
      busy_r <= !last;
      idx_r  <= idx_r + 3'd1;
    end
  end

  // next word moves into the low bits after each transfer
  always_ff @(posedge clk) begin
    if (load) begin
      q_r   <= q_i;
      ctl_r <= ctl_i;
    end else if (fire) begin
      q_r   <= q_r >> ctl_r.wb;
    end
  end

  always_comb begin
    out_ch.valid      = busy_r;
    out_ch.word_index = idx_r;
    out_ch.saturated  = ctl_r.sat;
    out_ch.last       = last;
    if (ctl_r.zero)     out_ch.word_value = 32'd0;
    else if (ctl_r.sat) out_ch.word_value = mask;
    else                out_ch.word_value = q_r[31:0] & mask;
  end

endmodule
`default_nettype wire

>>> hw/rtl/double_to_scaled_words.sv
// ----------------------------------------------------------------------------
// double_to_scaled_words
// Quantizes a binary64 value to round(value / resolution), ties up, exactly,
// saturates, and sends the result out as a run of words, low word first.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid / ready    | value_bits[63:0]
//  out_ch   | out | valid / ready    | word_index[2:0] word_value[31:0]
//           |     |                  | saturated last
//  cfg      | in  | cfg_we           | cfg_index[1:0] cfg_data[63:0]
//
//  The first word follows four front stages, a divider of 16*MAX_WORDS stages
//  at two quotient bits each, and the output register.
//  An item enters every cycle unless the pipeline is stalled; the output
//  register holds each item until all its words are sent, one word per transfer.
//  Reset is synchronous and clears all valid bits and the configuration.
//  A stall on out_ch freezes the pipeline in place once its last stage holds an item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module double_to_scaled_words #(
  parameter int MAX_WORDS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  dts_in_if.sink           in_ch,
  dts_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int QW  = 32 * MAX_WORDS;
  localparam int XW  = QW + 108;
  localparam int TW  = $clog2(QW + 1);
  localparam int NST = QW / 2;

  // configuration registers
  logic [63:0] res_r;
  logic [5:0]  wb_r;
  logic [3:0]  wc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= dts_pkg::RESOLUTION_RST;
      wb_r  <= dts_pkg::WORD_BITS_RST;
      wc_r  <= dts_pkg::WORD_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dts_pkg::REG_RESOLUTION: res_r <= cfg_data;
        dts_pkg::REG_WORD_BITS:  wb_r  <= cfg_data[5:0];
        dts_pkg::REG_WORD_COUNT: wc_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign in_ch.ready = en;

  // divider chain, index 0 fed by the front
  logic                      v_s   [NST+1];
  dts_pkg::ctl_t             ctl_s [NST+1];
  logic [dts_pkg::DEN_W-1:0] rem_s [NST+1];
  logic [dts_pkg::DEN_W-1:0] den_s [NST+1];
  logic [QW-1:0]             sh_s  [NST+1];

  dts_front #(.MAX_WORDS(MAX_WORDS), .QW(QW), .XW(XW), .TW(TW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_ch.valid),
    .value_bits (in_ch.value_bits),
    .res_bits   (res_r),
    .wb_cfg     (wb_r),
    .wc_cfg     (wc_r),
    .v_o        (v_s[0]),
    .ctl_o      (ctl_s[0]),
    .rem_o      (rem_s[0]),
    .den_o      (den_s[0]),
    .lo_o       (sh_s[0])
  );

  for (genvar g = 0; g < NST; g++) begin : g_div
    dts_div_stage #(.QW(QW)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .v_i   (v_s[g]),
      .ctl_i (ctl_s[g]),
      .rem_i (rem_s[g]),
      .den_i (den_s[g]),
      .sh_i  (sh_s[g]),
      .v_o   (v_s[g+1]),
      .ctl_o (ctl_s[g+1]),
      .rem_o (rem_s[g+1]),
      .den_o (den_s[g+1]),
      .sh_o  (sh_s[g+1])
    );
  end

  dts_emit #(.QW(QW)) u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .v_i    (v_s[NST]),
    .ctl_i  (ctl_s[NST]),
    .q_i    (sh_s[NST]),
    .en     (en),
    .out_ch (out_ch)
  );

  // a saturated word always has at least one bit set
  a_sat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |-> out_ch.word_value != 32'd0)
    else $error("saturated word is zero");

  // a run continues without a gap until its last word
  a_run_nogap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last |=> out_ch.valid)
    else $error("gap inside a word run");

  // a new run starts at word zero
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last |=>
      !out_ch.valid || out_ch.word_index == 3'd0)
    else $error("run does not start at word zero");

endmodule
`default_nettype wire

>>> tb/double_to_scaled_words_tb.sv
// ----------------------------------------------------------------------------
// double_to_scaled_words_tb
// Self-checking bench for the binary64 to scaled word converter. A local
// exact-rounding model predicts each output word run; the bench drives
// directed corner values and then random values over several register
// settings, with random idling, one long output stall and one drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module double_to_scaled_words_tb;

  localparam logic [1:0] REG_UNUSED = 2'd3;   // index past the register list
  localparam int PIPE_CYCLES = 4 + 16 * 8 + 16;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [2:0]  word_index;
    logic [31:0] word_value;
    logic        saturated;
    logic        last;
  } word_t;

  // Exact quantizer model and store of expected words
  class word_scoreboard;
    logic [63:0] resolution;
    logic [5:0]  word_bits;
    logic [3:0]  words_per_item;
    word_t       expected_words[$];
    int          errors;
    int          words_seen;

    function void reset_regs();
      resolution     = dts_pkg::RESOLUTION_RST;
      word_bits      = dts_pkg::WORD_BITS_RST;
      words_per_item = dts_pkg::WORD_COUNT_RST;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        dts_pkg::REG_RESOLUTION: resolution     = data;
        dts_pkg::REG_WORD_BITS:  word_bits      = data[5:0];
        dts_pkg::REG_WORD_COUNT: words_per_item = data[3:0];
        default: ;
      endcase
    endfunction

    function int eff_bits();
      return (word_bits == 0) ? 1 : (word_bits > 32) ? 32 : int'(word_bits);
    endfunction

    function int eff_count();
      return (words_per_item == 0) ? 1 : (words_per_item > 8) ? 8 : int'(words_per_item);
    endfunction

    // Quantize one value and queue its word run
    function void note_value(logic [63:0] v);
      int wb, wc, total_bits, ev, er, d, s;
      logic [63:0] mv, mr;
      logic [383:0] num, add_t, den, quot;
      logic [31:0] mask, w;
      bit sat, res_ok, v_spec, v_nan;
      word_t item;
      wb = eff_bits();
      wc = eff_count();
      total_bits = wb * wc;
      sat = 0;
      quot = '0;
      res_ok = !resolution[63] && resolution[62:52] != 11'h7FF && resolution[62:0] != 0;
      v_spec = v[62:52] == 11'h7FF;
      v_nan = v_spec && v[51:0] != 0;
      if (res_ok && !v[63] && !v_nan) begin
        if (v_spec) begin
          sat = 1;
        end else begin
          mv = (v[62:52] == 0) ? {12'd0, v[51:0]} : {11'd0, 1'b1, v[51:0]};
          ev = (v[62:52] == 0) ? -1074 : int'(v[62:52]) - 1075;
          mr = (resolution[62:52] == 0) ? {12'd0, resolution[51:0]}
                                        : {11'd0, 1'b1, resolution[51:0]};
          er = (resolution[62:52] == 0) ? -1074 : int'(resolution[62:52]) - 1075;
          d = ev - er;
          if (mv == 0 || d <= -55) begin
            quot = '0;
          end else if (d >= total_bits + 53) begin
            sat = 1;
          end else begin
            // floor((mv*2^(d+1) + mr) / (2*mr)), aligned to integers
            s = d + 1;
            if (s >= 0) begin
              num = 384'(mv) << s;
              add_t = 384'(mr);
              den = 384'(mr) << 1;
            end else begin
              num = 384'(mv);
              add_t = 384'(mr) << (-s);
              den = 384'(mr) << (1 - s);
            end
            quot = (num + add_t) / den;
            if ((quot >> total_bits) != 0) sat = 1;
          end
        end
      end
      mask = (wb == 32) ? 32'hFFFF_FFFF : ((32'd1 << wb) - 32'd1);
      for (int k = 0; k < wc; k++) begin
        w = sat ? mask : (32'(quot >> (k * wb)) & mask);
        item.word_index = 3'(k);
        item.word_value = w;
        item.saturated  = sat;
        item.last       = (k == wc - 1);
        expected_words.insert(expected_words.size(), item);
      end
    endfunction

    function void check_word(word_t got);
      word_t exp_w;
      words_seen++;
      if (expected_words.size() == 0) begin
        $error("unexpected word: index %0d value %h", got.word_index, got.word_value);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.word_index !== exp_w.word_index) begin
        $error("word_index: expected %0d, got %0d", exp_w.word_index, got.word_index);
        errors++;
      end
      if (got.word_value !== exp_w.word_value) begin
        $error("word_value: expected %h, got %h", exp_w.word_value, got.word_value);
        errors++;
      end
      if (got.saturated !== exp_w.saturated) begin
        $error("saturated: expected %0b, got %0b", exp_w.saturated, got.saturated);
        errors++;
      end
      if (got.last !== exp_w.last) begin
        $error("last: expected %0b, got %0b", exp_w.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          send_idle_pct = 12;
  int          recv_idle_pct = 47;
  logic        hold_req = 1'b0;
  int          hold_left = 0;
  int          values_sent = 0;
  word_scoreboard sb;

  dts_in_if  in_ch ();
  dts_out_if out_ch ();

  double_to_scaled_words dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.value_bits = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: check accepted words, random stalls, long hold-off
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word({out_ch.word_index, out_ch.word_value, out_ch.saturated, out_ch.last});
    if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
    out_ch.ready <= rst_n && !hold_req && hold_left <= 1 &&
                    ($urandom_range(99) >= recv_idle_pct);
  end

  // One register write; cfg_we is low again when the task returns
  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Offer one value; valid stays high into the next item unless it idles
  task automatic send_value(logic [63:0] v);
    if (values_sent == 55) begin
      send_idle_pct = 47;
      recv_idle_pct = 12;
    end else if (values_sent == 110) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value_bits <= v;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_value(v);
    values_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  // Random value, mostly scaled near the active resolution and word span
  function automatic logic [63:0] pick_value();
    int sel, re, ex;
    logic [63:0] v;
    sel = $urandom_range(99);
    v = {$urandom, $urandom};
    re = int'(sb.resolution[62:52]);
    if (sel < 8) begin
      v[62:52] = (sel < 4) ? 11'h7FF : 11'h000;   // specials and subnormals
    end else if (sel < 75) begin
      ex = re + $urandom_range(0, sb.eff_bits() * sb.eff_count() + 60) - 57;
      ex = (ex < 0) ? 0 : (ex > 2046) ? 2046 : ex;
      v[62:52] = 11'(ex);
      v[63] = ($urandom_range(9) == 0);
      if ($urandom_range(3) == 0) v[40:0] = {1'b1, 40'd0};   // near rounding ties
    end
    return v;
  endfunction

  logic [63:0] directed_vals[16] = '{
    64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
    64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0000, 64'h7FF0_0000_0000_0001,
    64'h3FE0_0000_0000_0000, 64'h3FDF_FFFF_FFFF_FFFF, 64'h3FF8_0000_0000_0000,
    64'h4004_0000_0000_0000, 64'h41EF_FFFF_FFE0_0000, 64'h41EF_FFFF_FFF0_0000,
    64'h41F0_0000_0000_0000, 64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF};

  // Register settings per phase: resolution, word bits, word count, values
  logic [63:0] phase_res[10] = '{
    64'h3FF0_0000_0000_0000, 64'h3FD0_0000_0000_0000, 64'h3F50_624D_D2F1_A9FC,
    64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
    64'hBFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
    64'h3FF0_0000_0000_0001};
  int phase_wb[10]  = '{8, 1, 32, 13, 32, 5, 7, 9, 11, 32};
  int phase_wc[10]  = '{4, 8, 8, 3, 2, 2, 1, 3, 2, 1};
  int phase_len[10] = '{20, 20, 24, 16, 12, 4, 4, 4, 4, 36};

  initial begin
    sb = new();
    sb.reset_regs();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_vals[i]) send_value(directed_vals[i]);
    drain();
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);

    for (int p = 0; p < 10; p++) begin
      write_reg(dts_pkg::REG_RESOLUTION, phase_res[p]);
      write_reg(dts_pkg::REG_WORD_BITS, 64'(phase_wb[p]));
      write_reg(dts_pkg::REG_WORD_COUNT, 64'(phase_wc[p]));
      for (int n = 0; n < phase_len[p]; n++) begin
        // long output stall while inputs keep coming, full-width runs
        if (p == 2 && n == 2) begin
          in_ch.valid <= 1'b0;
          hold_req <= 1'b1;
          @(posedge clk);
          hold_req <= 1'b0;
        end
        // input pause until all words are out
        if (p == 2 && n == 14) drain();
        send_value(pick_value());
      end
      drain();
    end

    $display("Covered %0d values and %0d words over %0d register settings,", values_sent,
             sb.words_seen, 11);
    $display("including invalid resolutions, specials, saturation and a long stall.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("double_to_scaled_words verification clean");
    end else begin
      $display("double_to_scaled_words verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("double_to_scaled_words verification failed");
    $finish;
  end

endmodule
